@@ hdl/cav_pkg.sv @@
// shared constants, types and helpers for the comb/allpass reverb
package cav_pkg;
  localparam int SAMPLE_RATE_DEF = 44100;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int BASE_RATE = 44100;
  localparam int GAIN_W = 17;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic [1:0] REG_ROOM = 2'd0;
  localparam logic [1:0] REG_DAMP = 2'd1;
  localparam logic [1:0] REG_WET  = 2'd2;
  localparam logic [1:0] REG_ON   = 2'd3;

  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_COMB  = 3'd2;
  localparam logic [2:0] OP_MEAN  = 3'd3;
  localparam logic [2:0] OP_AP    = 3'd4;
  localparam logic [2:0] OP_MIX   = 3'd5;
  localparam logic [2:0] OP_BYP   = 3'd6;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] line;
    logic [1:0] phase;
  } cav_cmd_t;

  typedef struct packed {
    logic effect_on;
  } cav_sts_t;

  function automatic int comb_base(input int k);
    case (k)
      0: comb_base = 1116;
      1: comb_base = 1188;
      2: comb_base = 1277;
      3: comb_base = 1356;
      4: comb_base = 1422;
      5: comb_base = 1491;
      6: comb_base = 1557;
      default: comb_base = 1617;
    endcase
  endfunction

  function automatic int ap_base(input int k);
    case (k)
      0: ap_base = 556;
      1: ap_base = 441;
      2: ap_base = 341;
      default: ap_base = 225;
    endcase
  endfunction

  function automatic int line_len(input int base, input int rate);
    longint l;
    l = (longint'(base) * rate) / BASE_RATE;
    line_len = (l == 0) ? 1 : int'(l);
  endfunction

  function automatic int clog2i(input int v);
    int r;
    r = 0;
    while ((1 << r) < v) r++;
    clog2i = (r == 0) ? 1 : r;
  endfunction
endpackage

@@ hdl/cav_ctrl.sv @@
// sequencer that steps the datapath through one sample
module cav_ctrl import cav_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  cav_sts_t sts,
  output cav_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMB = 3'd1;
  localparam logic [2:0] S_MEAN = 3'd2;
  localparam logic [2:0] S_AP   = 3'd3;
  localparam logic [2:0] S_MIX  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] line_r, line_nxt;
  logic [1:0] phase_r, phase_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    phase_nxt = phase_r;
    cmd.op    = OP_IDLE;
    cmd.line  = line_r;
    cmd.phase = phase_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          line_nxt  = '0;
          phase_nxt = '0;
          if (sts.effect_on) begin
            cmd.op = OP_LOAD;
            state_nxt = S_COMB;
          end else begin
            cmd.op = OP_BYP;
            state_nxt = S_OUT;
          end
        end
      end
      S_COMB: begin
        cmd.op = OP_COMB;
        phase_nxt = phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          line_nxt = line_r + 4'd1;
          if (line_r == 4'd7) begin
            line_nxt = '0;
            state_nxt = S_MEAN;
          end
        end
      end
      S_MEAN: begin
        cmd.op = OP_MEAN;
        state_nxt = S_AP;
        phase_nxt = '0;
      end
      S_AP: begin
        cmd.op = OP_AP;
        phase_nxt = phase_r + 2'd1;
        if (phase_r == 2'd2) begin
          phase_nxt = '0;
          line_nxt = line_r + 4'd1;
          if (line_r == 4'd3) begin
            line_nxt = '0;
            state_nxt = S_MIX;
          end
        end
      end
      S_MIX: begin
        cmd.op = OP_MIX;
        phase_nxt = phase_r + 2'd1;
        if (phase_r == 2'd1) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      line_r  <= '0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
      phase_r <= phase_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("beat dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while holding result");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEAN) |=> (state_r == S_AP)) else $error("bad sequence");
endmodule

@@ hdl/cav_dp.sv @@
// datapath: delay memories, shared multiplier and accumulators
module cav_dp import cav_pkg::*; #(
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cav_cmd_t                      cmd,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  input  logic                          be_in,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [GAIN_W-1:0]             cfg_data,
  output cav_sts_t                      sts,
  output logic signed [SAMPLE_BITS-1:0] y_out,
  output logic                          be_out
);
  localparam int IW = SAMPLE_BITS + 4;
  localparam int CL_MAX = line_len(1617, SAMPLE_RATE) + 1;
  localparam int AL_MAX = line_len(556, SAMPLE_RATE) + 1;
  localparam int CLW = clog2i(CL_MAX);
  localparam int ALW = clog2i(AL_MAX);
  localparam int CDEPTH = 8 * CL_MAX;
  localparam int ADEPTH = 4 * AL_MAX;
  localparam int CAW = clog2i(CDEPTH);
  localparam int AAW = clog2i(ADEPTH);
  localparam int PW = IW + 19;
  localparam int CLRW = (CAW > AAW) ? CAW + 1 : AAW + 1;
  localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  // line lengths, line k at bits [k*width +: width]
  localparam logic [8*CLW-1:0] CLENS = {
    CLW'(line_len(comb_base(7), SAMPLE_RATE)), CLW'(line_len(comb_base(6), SAMPLE_RATE)),
    CLW'(line_len(comb_base(5), SAMPLE_RATE)), CLW'(line_len(comb_base(4), SAMPLE_RATE)),
    CLW'(line_len(comb_base(3), SAMPLE_RATE)), CLW'(line_len(comb_base(2), SAMPLE_RATE)),
    CLW'(line_len(comb_base(1), SAMPLE_RATE)), CLW'(line_len(comb_base(0), SAMPLE_RATE))
  };
  localparam logic [4*ALW-1:0] ALENS = {
    ALW'(line_len(ap_base(3), SAMPLE_RATE)), ALW'(line_len(ap_base(2), SAMPLE_RATE)),
    ALW'(line_len(ap_base(1), SAMPLE_RATE)), ALW'(line_len(ap_base(0), SAMPLE_RATE))
  };

  logic [GAIN_W-1:0] room_r, damp_r, wet_r;
  logic              on_r;
  logic [CLW-1:0] cpos_r [8];
  logic [ALW-1:0] apos_r [4];
  logic signed [IW-1:0] cmem [CDEPTH];
  logic signed [IW-1:0] amem [ADEPTH];
  logic signed [IW-1:0] crd_r, ard_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [IW+3:0] sum_r;
  logic signed [IW-1:0] v_r, b_r;
  logic signed [PW-1:0] acc_r;
  logic [CLRW-1:0] clr_r;
  logic clr_busy;

  function automatic logic signed [IW-1:0] sat_i(input logic signed [PW-1:0] v);
    if (v > PW'(IMAX)) sat_i = IMAX;
    else if (v < PW'(IMIN)) sat_i = IMIN;
    else sat_i = v[IW-1:0];
  endfunction

  function automatic logic [GAIN_W-1:0] gclip(input logic [GAIN_W-1:0] g);
    gclip = (g > ONE_Q16) ? ONE_Q16 : g;
  endfunction

  logic [GAIN_W-1:0] dg, rg, wg;
  assign dg = gclip(damp_r);
  assign rg = gclip(room_r);
  assign wg = gclip(wet_r);

  logic [2:0] cl;
  logic [1:0] al;
  assign cl = cmd.line[2:0];
  assign al = cmd.line[1:0];

  logic [CLW-1:0] clen, cp, cp_inc;
  logic [ALW-1:0] alen, ap, ap_inc;
  always_comb begin
    clen = CLENS[cl*CLW +: CLW];
    alen = ALENS[al*ALW +: ALW];
    cp = (cpos_r[cl] >= clen) ? '0 : cpos_r[cl];
    ap = (apos_r[al] >= alen) ? '0 : apos_r[al];
    cp_inc = (cp + CLW'(1) >= clen) ? '0 : cp + CLW'(1);
    ap_inc = (ap + ALW'(1) >= alen) ? '0 : ap + ALW'(1);
  end

  logic [CAW-1:0] caddr;
  logic [AAW-1:0] aaddr;
  assign caddr = CAW'(int'(cl) * CL_MAX) + CAW'(cp);
  assign aaddr = AAW'(int'(al) * AL_MAX) + AAW'(ap);

  // one multiplier, operands chosen by phase
  logic signed [IW+1:0] ma;
  logic signed [GAIN_W:0] mb;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd16;
  logic signed [PW-1:0] rnd_p;
  logic signed [IW-1:0] filt;
  assign rnd16 = (acc_r + PW'(32768)) >>> 16;
  assign filt = rnd16[IW-1:0];
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd.op == OP_COMB) begin
      case (cmd.phase)
        2'd1: begin ma = (IW+2)'(crd_r); mb = $signed({1'b0, ONE_Q16 - dg}); end
        2'd2: begin ma = (IW+2)'(x_r); mb = $signed({1'b0, dg}); end
        default: begin ma = (IW+2)'(filt); mb = $signed({1'b0, rg}); end
      endcase
    end else begin
      if (cmd.phase == 2'd0) begin ma = (IW+2)'(x_r); mb = $signed({1'b0, ONE_Q16 - wg}); end
      else begin ma = (IW+2)'(v_r); mb = $signed({1'b0, wg}); end
    end
  end
  assign prod = PW'(ma * mb);
  assign rnd_p = (prod + PW'(32768)) >>> 16;

  logic signed [PW-1:0] mean_w, ysum;
  logic signed [SAMPLE_BITS-1:0] ysat;
  assign mean_w = PW'((sum_r + (IW+4)'(4)) >>> 3);
  assign ysum = (acc_r + prod + PW'(32768)) >>> 16;
  always_comb begin
    if (ysum > PW'(SMAX)) ysat = SMAX;
    else if (ysum < PW'(SMIN)) ysat = SMIN;
    else ysat = ysum[SAMPLE_BITS-1:0];
  end

  assign clr_busy = !clr_r[CLRW-1];
  assign sts.effect_on = on_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_r <= GAIN_W'(32768);
      damp_r <= GAIN_W'(32768);
      wet_r  <= ONE_Q16;
      on_r   <= 1'b1;
      clr_r  <= '0;
      for (int i = 0; i < 8; i++) cpos_r[i] <= '0;
      for (int i = 0; i < 4; i++) apos_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROOM: room_r <= cfg_data;
          REG_DAMP: damp_r <= cfg_data;
          REG_WET:  wet_r  <= cfg_data;
          REG_ON:   on_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (clr_busy) clr_r <= clr_r + CLRW'(1);
      if (cmd.op == OP_COMB && cmd.phase == 2'd3) cpos_r[cl] <= cp_inc;
      if (cmd.op == OP_AP && cmd.phase == 2'd2) apos_r[al] <= ap_inc;
    end
  end

  // memories; clearing pass after reset reuses the write port
  always_ff @(posedge clk) begin
    crd_r <= cmem[caddr];
    ard_r <= amem[aaddr];
    if (clr_busy) begin
      if (clr_r[CLRW-2:0] < (CLRW-1)'(CDEPTH)) cmem[clr_r[CAW-1:0]] <= '0;
      if (clr_r[CLRW-2:0] < (CLRW-1)'(ADEPTH)) amem[clr_r[AAW-1:0]] <= '0;
    end else begin
      if (cmd.op == OP_COMB && cmd.phase == 2'd3)
        cmem[caddr] <= sat_i(PW'(x_r) + rnd_p);
      if (cmd.op == OP_AP && cmd.phase == 2'd2)
        amem[aaddr] <= sat_i(PW'(v_r) + PW'((PW'(b_r) + PW'(1)) >>> 1));
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x_r <= x_in; be_out <= be_in; sum_r <= '0;
      end
      OP_BYP: begin
        y_out <= x_in; be_out <= be_in;
      end
      OP_COMB: begin
        case (cmd.phase)
          2'd1: begin sum_r <= sum_r + (IW+4)'(crd_r); acc_r <= prod; end
          2'd2: acc_r <= acc_r + prod;
          2'd3: acc_r <= prod;
          default: ;
        endcase
      end
      OP_MEAN: v_r <= sat_i(mean_w);
      OP_AP: begin
        if (cmd.phase == 2'd1) b_r <= ard_r;
        if (cmd.phase == 2'd2) v_r <= sat_i(PW'(b_r) - PW'(v_r));
      end
      OP_MIX: begin
        if (cmd.phase == 2'd0) acc_r <= prod;
        else y_out <= ysat;
      end
      default: ;
    endcase
  end
endmodule

@@ hdl/comb_allpass_reverb.sv @@
// top level of the eight-comb, four-allpass reverb
// channel | ports                                   | direction
// in      | in_valid/in_ready, in_sample_in, in_block_end_in   | in
// out     | out_valid/out_ready, out_sample_out, out_block_end_out | out
// cfg     | cfg_we, cfg_idx, cfg_data               | in
// a processed sample goes through 8 comb lines x 4 steps on the shared
// multiplier, 4 allpass stages x 3 steps on the delay memory port, mean and mix
// bypassed samples skip these steps; the result is held until out_ready
// after reset a clearing pass zeroes the delay memories; no sample is
// accepted until it finishes
module comb_allpass_reverb import cav_pkg::*; #(
  parameter int SAMPLE_RATE = SAMPLE_RATE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          in_block_end_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_block_end_out,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_idx,
  input  logic [GAIN_W-1:0]             cfg_data
);
  localparam int CDEPTH = 8 * (line_len(1617, SAMPLE_RATE) + 1);
  localparam int CW = clog2i(CDEPTH) + 2;
  localparam int CLR_CYC = 1 << clog2i(CDEPTH);
  cav_cmd_t cmd;
  cav_sts_t sts;
  logic ctl_ready;
  logic [CW-1:0] wait_r;
  logic ready_ok;
  assign ready_ok = (wait_r >= CW'(CLR_CYC + 2));
  assign in_ready = ctl_ready && ready_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) wait_r <= '0;
    else if (!ready_ok) wait_r <= wait_r + CW'(1);
  end

  cav_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_valid && ready_ok), .in_ready(ctl_ready),
    .out_valid, .out_ready, .sts, .cmd
  );

  cav_dp #(.SAMPLE_RATE(SAMPLE_RATE), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst_n, .cmd,
    .x_in(in_sample_in), .be_in(in_block_end_in),
    .cfg_we, .cfg_idx, .cfg_data, .sts,
    .y_out(out_sample_out), .be_out(out_block_end_out)
  );
endmodule
